@@ rtl/core/cmm_pkg.sv @@
// shared types and constants of the channel mixing matrix
package cmm_pkg;

	// input mode codes
	localparam logic [1:0] MODE_COEF  = 2'd0;
	localparam logic [1:0] MODE_FRAME = 2'd1;
	localparam logic [1:0] MODE_MIX   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_SRC_CH  = 2'd0;
	localparam logic [1:0] CFG_DST_CH  = 2'd1;
	localparam logic [1:0] CFG_VOL_DST = 2'd2;
	localparam logic [1:0] CFG_VOL_SRC = 2'd3;

	// configuration reset values
	localparam logic [3:0]         RST_CH_COUNT = 4'd2;
	localparam logic signed [15:0] RST_VOL      = 16'sd4096;

	// work queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		KIND_COEF,
		KIND_FRAME,
		KIND_MIX,
		KIND_BAD
	} cmm_kind_t;

	typedef struct packed {
		cmm_kind_t          kind;
		logic [2:0]         src_ch;
		logic [2:0]         dst_ch;
		logic signed [15:0] coef;
	} cmm_cmd_t;

endpackage

@@ rtl/core/cmm_front.sv @@
// front end: accepts input beats, range-checks channels, classifies into commands
module cmm_front #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [2:0]                    src_channel,
	input  logic [2:0]                    dst_channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [15:0]            coefficient,
	input  logic [$clog2(MAX_CHANNELS+1)-1:0] ns,
	input  logic [$clog2(MAX_CHANNELS+1)-1:0] nd,
	input  logic                          q_full,
	output logic                          q_push,
	output cmm_pkg::cmm_cmd_t             q_cmd,
	output logic signed [SAMPLE_BITS-1:0] q_sample
);

	logic src_bad;
	logic dst_bad;
	logic keep;

	// channel range checks against the effective counts
	assign src_bad = 32'(src_channel) >= 32'(ns);
	assign dst_bad = 32'(dst_channel) >= 32'(nd);

	// classify the beat
	always_comb begin
		keep          = 1'b1;
		q_cmd.kind    = cmm_pkg::KIND_BAD;
		q_cmd.src_ch  = src_channel;
		q_cmd.dst_ch  = dst_channel;
		q_cmd.coef    = coefficient;
		case (mode)
			cmm_pkg::MODE_COEF: begin
				q_cmd.kind = (src_bad || dst_bad) ? cmm_pkg::KIND_BAD : cmm_pkg::KIND_COEF;
			end
			cmm_pkg::MODE_FRAME: begin
				q_cmd.kind = src_bad ? cmm_pkg::KIND_BAD : cmm_pkg::KIND_FRAME;
				// a bad source write reports channel zero
				if (src_bad) begin
					q_cmd.dst_ch = 3'd0;
				end
			end
			cmm_pkg::MODE_MIX: begin
				q_cmd.kind = dst_bad ? cmm_pkg::KIND_BAD : cmm_pkg::KIND_MIX;
			end
			default: begin
				// unused mode is dropped
				keep = 1'b0;
			end
		endcase
	end

	assign q_sample = sample;
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

endmodule

@@ rtl/core/cmm_fifo.sv @@
// short command queue between front and back
module cmm_fifo #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  cmm_pkg::cmm_cmd_t             push_cmd,
	input  logic signed [SAMPLE_BITS-1:0] push_sample,
	output logic                          full,
	input  logic                          pop,
	output logic                          head_valid,
	output cmm_pkg::cmm_cmd_t             head_cmd,
	output logic signed [SAMPLE_BITS-1:0] head_sample
);

	localparam int DEPTH = cmm_pkg::QUEUE_DEPTH;
	localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	cmm_pkg::cmm_cmd_t             cmd_q    [DEPTH];
	logic signed [SAMPLE_BITS-1:0] sample_q [DEPTH];
	logic [PTRW-1:0]               wr_ptr_q;
	logic [PTRW-1:0]               rd_ptr_q;
	logic [CNTW-1:0]               count_q;

	assign full        = count_q == CNTW'(DEPTH);
	assign head_valid  = count_q != '0;
	assign head_cmd    = cmd_q[rd_ptr_q];
	assign head_sample = sample_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]    <= push_cmd;
			sample_q[wr_ptr_q] <= push_sample;
		end
	end

endmodule

@@ rtl/core/cmm_back.sv @@
// back end: coefficient and frame stores, shared mac, scaling, rounding, output register
module cmm_back #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  cmm_pkg::cmm_cmd_t             q_cmd,
	input  logic signed [SAMPLE_BITS-1:0] q_sample,
	output logic                          q_pop,
	input  logic [$clog2(MAX_CHANNELS+1)-1:0] ns,
	input  logic signed [15:0]            vol_dst,
	input  logic signed [15:0]            vol_src,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] mixed_sample,
	output logic [2:0]                    out_channel,
	output logic                          clipped,
	output logic                          bad_channel
);

	localparam int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CAW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS * MAX_CHANNELS) : 1;
	localparam int CD   = MAX_CHANNELS * MAX_CHANNELS;
	localparam int CNTW = $clog2(MAX_CHANNELS + 1);
	localparam int PW   = SAMPLE_BITS + 16;
	localparam int AW   = PW + $clog2(MAX_CHANNELS + 1);
	localparam int P2W  = AW + 9;
	localparam int DW   = SAMPLE_BITS + 16;
	localparam int TW   = AW + 18;
	localparam int FRAC = 24;
	localparam logic signed [TW-1:0] RND_BIAS = {{(TW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SC_A,
		ST_SC_B,
		ST_SC_C,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [CNTW-1:0]               c_q;
	logic                          v_s1;
	logic                          v_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mixed_q;
	logic [2:0]                    out_ch_q;
	logic                          clip_q;
	logic                          bad_q;

	logic signed [15:0]            coef_mem [CD];
	logic [CD-1:0]                 coef_vld_q;
	logic signed [SAMPLE_BITS-1:0] frame_q  [MAX_CHANNELS];

	logic [2:0]                    dc_q;
	logic signed [SAMPLE_BITS-1:0] dsample_q;
	logic signed [SAMPLE_BITS-1:0] frame_s1;
	logic signed [15:0]            coef_rd_s1;
	logic                          cvld_s1;
	logic signed [PW-1:0]          prod_s2;
	logic signed [AW-1:0]          acc_q;
	logic signed [P2W-1:0]         p_q;
	logic signed [DW-1:0]          dv_q;
	logic signed [TW-1:0]          tot_q;

	logic                          out_free;
	logic                          out_load;
	logic                          issue;
	logic [CAW-1:0]                wr_addr;
	logic [CAW-1:0]                rd_addr;
	logic [IW-1:0]                 frame_wr_idx;
	logic [IW-1:0]                 frame_rd_idx;
	logic signed [15:0]            coef_eff_s1;
	logic signed [AW-1:0]          prod_ext;
	logic signed [TW-1:0]          p_ext;
	logic signed [TW-1:0]          dv_ext;
	logic signed [8:0]             vs_lo;
	logic signed [7:0]             vs_hi;
	logic [TW-FRAC-SAMPLE_BITS:0]  upper;
	logic                          sat_hi;
	logic                          sat_lo;
	logic signed [SAMPLE_BITS-1:0] res_sample;

	// handshake and sequencing controls
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_valid
		&& ((q_cmd.kind != cmm_pkg::KIND_BAD) || out_free);
	assign issue    = (state_q == ST_MAC) && (c_q < ns);
	assign out_load = (q_pop && (q_cmd.kind == cmm_pkg::KIND_BAD))
		|| ((state_q == ST_DONE) && out_free);

	// store addressing
	assign wr_addr      = CAW'(int'(q_cmd.src_ch) * MAX_CHANNELS + int'(q_cmd.dst_ch));
	assign rd_addr      = CAW'(int'(c_q) * MAX_CHANNELS + int'(dc_q));
	assign frame_wr_idx = IW'(q_cmd.src_ch);
	assign frame_rd_idx = c_q[IW-1:0];

	// operand shaping
	assign coef_eff_s1 = cvld_s1 ? coef_rd_s1 : '0;
	assign vs_lo       = $signed({1'b0, vol_src[7:0]});
	assign vs_hi       = vol_src[15:8];

	always_comb begin
		prod_ext = AW'(prod_s2);
		p_ext    = TW'(p_q);
		dv_ext   = TW'(dv_q);
	end

	// round half up is already in the total; saturate to sample range
	assign upper      = tot_q[TW-1:FRAC+SAMPLE_BITS-1];
	assign sat_hi     = !tot_q[TW-1] && (|upper);
	assign sat_lo     = tot_q[TW-1] && !(&upper);
	assign res_sample = sat_hi ? SAT_MAX : (sat_lo ? SAT_MIN : tot_q[FRAC+SAMPLE_BITS-1:FRAC]);

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			c_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			mixed_q     <= '0;
			out_ch_q    <= '0;
			clip_q      <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					v_s1 <= 1'b0;
					v_s2 <= 1'b0;
					if (q_pop) begin
						case (q_cmd.kind)
							cmm_pkg::KIND_BAD: begin
								out_valid_q <= 1'b1;
								mixed_q     <= '0;
								out_ch_q    <= q_cmd.dst_ch;
								clip_q      <= 1'b0;
								bad_q       <= 1'b1;
							end
							cmm_pkg::KIND_MIX: begin
								c_q     <= '0;
								state_q <= ST_MAC;
							end
							default: begin
								// store writes finish in the pop cycle
							end
						endcase
					end
				end
				ST_MAC: begin
					if (issue) begin
						c_q <= c_q + 1'b1;
					end
					v_s1 <= issue;
					v_s2 <= v_s1;
					if (!issue && !v_s1 && !v_s2) begin
						state_q <= ST_SC_A;
					end
				end
				ST_SC_A: begin
					state_q <= ST_SC_B;
				end
				ST_SC_B: begin
					state_q <= ST_SC_C;
				end
				ST_SC_C: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						mixed_q     <= res_sample;
						out_ch_q    <= dc_q;
						clip_q      <= sat_hi || sat_lo;
						bad_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// coefficient memory, registered read
	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.kind == cmm_pkg::KIND_COEF)) begin
			coef_mem[wr_addr] <= q_cmd.coef;
		end
		coef_rd_s1 <= coef_mem[rd_addr];
	end

	// coefficient entries read as zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (q_pop && (q_cmd.kind == cmm_pkg::KIND_COEF)) begin
			coef_vld_q[wr_addr] <= 1'b1;
		end
	end

	// current frame samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				frame_q[i] <= '0;
			end
		end else if (q_pop && (q_cmd.kind == cmm_pkg::KIND_FRAME)) begin
			frame_q[frame_wr_idx] <= q_sample;
		end
	end

	// mac pipeline and gain scaling datapath
	always_ff @(posedge clk) begin
		frame_s1 <= frame_q[frame_rd_idx];
		cvld_s1  <= coef_vld_q[rd_addr];
		prod_s2  <= frame_s1 * coef_eff_s1;
		if (q_pop) begin
			dc_q      <= q_cmd.dst_ch;
			dsample_q <= q_sample;
			acc_q     <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_ext;
		end
		case (state_q)
			ST_SC_A: begin
				p_q  <= acc_q * vs_lo;
				dv_q <= dsample_q * vol_dst;
			end
			ST_SC_B: begin
				tot_q <= p_ext + (dv_ext <<< 12) + RND_BIAS;
				p_q   <= acc_q * vs_hi;
			end
			ST_SC_C: begin
				tot_q <= tot_q + (p_ext <<< 8);
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign out_channel  = out_ch_q;
	assign clipped      = clip_q;
	assign bad_channel  = bad_q;

endmodule

@@ rtl/core/channel_mix_matrix_top.sv @@
// top level of the channel mixing matrix: config registers, front, queue, back
//
//  channel | beat contents                                    | handshake
//  in      | mode, src_channel, dst_channel, sample, coeff.   | in_valid / in_stall
//  out     | mixed_sample, out_channel, clipped, bad_channel  | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                              | cfg_valid / cfg_ready
//
// coefficient, sample and bad-channel beats each finish in the back end's idle state;
// a mix beat walks the source channels through the single shared mac and then
// runs the two-digit gain multiply.
// a two-entry queue lets the front accept beats while the back is busy.
// after reset both stores read as zero; there is no clearing pass.
// cfg_ready is always high; in_stall is high only while the queue is full.
module channel_mix_matrix_top #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [2:0]                    src_channel,
	input  logic [2:0]                    dst_channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [15:0]            coefficient,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] mixed_sample,
	output logic [2:0]                    out_channel,
	output logic                          clipped,
	output logic                          bad_channel,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int CNTW = $clog2(MAX_CHANNELS + 1);
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [3:0]                    src_ch_q;
	logic [3:0]                    dst_ch_q;
	logic signed [15:0]            vol_dst_q;
	logic signed [15:0]            vol_src_q;
	logic [CNTW-1:0]               ns_eff;
	logic [CNTW-1:0]               nd_eff;
	logic                          q_full;
	logic                          q_push;
	cmm_pkg::cmm_cmd_t             push_cmd;
	logic signed [SAMPLE_BITS-1:0] push_sample;
	logic                          q_pop;
	logic                          q_valid;
	cmm_pkg::cmm_cmd_t             head_cmd;
	logic signed [SAMPLE_BITS-1:0] head_sample;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch_q  <= cmm_pkg::RST_CH_COUNT;
			dst_ch_q  <= cmm_pkg::RST_CH_COUNT;
			vol_dst_q <= cmm_pkg::RST_VOL;
			vol_src_q <= cmm_pkg::RST_VOL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cmm_pkg::CFG_SRC_CH:  src_ch_q  <= cfg_data[3:0];
				cmm_pkg::CFG_DST_CH:  dst_ch_q  <= cfg_data[3:0];
				cmm_pkg::CFG_VOL_DST: vol_dst_q <= cfg_data;
				cmm_pkg::CFG_VOL_SRC: vol_src_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// counts above the store size act as the store size
	assign ns_eff = (32'(src_ch_q) > MAX_CHANNELS) ? CNTW'(MAX_CHANNELS) : CNTW'(src_ch_q);
	assign nd_eff = (32'(dst_ch_q) > MAX_CHANNELS) ? CNTW'(MAX_CHANNELS) : CNTW'(dst_ch_q);

	cmm_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.src_channel(src_channel),
		.dst_channel(dst_channel),
		.sample     (sample),
		.coefficient(coefficient),
		.ns         (ns_eff),
		.nd         (nd_eff),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd),
		.q_sample   (push_sample)
	);

	cmm_fifo #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.push_sample(push_sample),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (head_cmd),
		.head_sample(head_sample)
	);

	cmm_back #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (head_cmd),
		.q_sample    (head_sample),
		.q_pop       (q_pop),
		.ns          (ns_eff),
		.vol_dst     (vol_dst_q),
		.vol_src     (vol_src_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mixed_sample(mixed_sample),
		.out_channel (out_channel),
		.clipped     (clipped),
		.bad_channel (bad_channel)
	);

	// bad-channel beats carry a zero, unclipped sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_channel |-> (mixed_sample == '0) && !clipped)
		else $error("bad channel beat with nonzero payload");

	// a clipped result sits at one of the rails
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (mixed_sample == SAT_MAX) || (mixed_sample == SAT_MIN))
		else $error("clipped result not at a rail");

	// a good mix result belongs to a configured destination channel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_channel |-> 32'(out_channel) < 32'(nd_eff))
		else $error("mix result on an unconfigured channel");

	// the front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");

endmodule

@@ bench/channel_mix_matrix_tb.sv @@
// self-checking testbench of the channel mixing matrix with its own mix predictor
`timescale 1ns / 1ps

module testbench;

	// one expected or observed output beat
	typedef struct packed {
		logic signed [15:0] mixed;
		logic [2:0]         chan;
		logic               clip;
		logic               bad;
	} mix_result_t;

	localparam int MAX_CH      = 8;
	localparam int SETTLE_CYC  = 64;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = cmm_pkg::MODE_NONE;
	logic [2:0]         src_channel = '0;
	logic [2:0]         dst_channel = '0;
	logic signed [15:0] sample = '0;
	logic signed [15:0] coefficient = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] mixed_sample;
	logic [2:0]         out_channel;
	logic               clipped;
	logic               bad_channel;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = cmm_pkg::CFG_SRC_CH;
	logic [15:0]        cfg_data = '0;

	channel_mix_matrix_top #(
		.MAX_CHANNELS(MAX_CH),
		.SAMPLE_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.src_channel(src_channel),
		.dst_channel(dst_channel),
		.sample(sample),
		.coefficient(coefficient),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mixed_sample(mixed_sample),
		.out_channel(out_channel),
		.clipped(clipped),
		.bad_channel(bad_channel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic signed [15:0] coef_mem [MAX_CH*MAX_CH];
	logic signed [15:0] frame_mem [MAX_CH];
	logic [3:0]         cfg_src_n = cmm_pkg::RST_CH_COUNT;
	logic [3:0]         cfg_dst_n = cmm_pkg::RST_CH_COUNT;
	logic signed [15:0] cfg_vol_dst = cmm_pkg::RST_VOL;
	logic signed [15:0] cfg_vol_src = cmm_pkg::RST_VOL;

	mix_result_t pending_mix [$];
	int          error_count = 0;
	int          beats_sent = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic int eff_count(input logic [3:0] n);
		return (n > MAX_CH) ? MAX_CH : int'(n);
	endfunction

	// expected result of one accepted beat; updates the predictor stores
	function automatic bit mix_predict(input logic [1:0] m, input logic [2:0] sc,
			input logic [2:0] dc, input logic signed [15:0] smp,
			input logic signed [15:0] coef, output mix_result_t r);
		int     ns;
		int     nd;
		bit     bad;
		longint acc;
		longint tot;
		longint val;
		longint hi;
		longint lo;
		ns = eff_count(cfg_src_n);
		nd = eff_count(cfg_dst_n);
		r = '0;
		hi = 32767;
		lo = -32768;
		if (m == cmm_pkg::MODE_NONE)
			return 0;
		case (m)
			cmm_pkg::MODE_COEF:  bad = (sc >= ns) || (dc >= nd);
			cmm_pkg::MODE_FRAME: bad = (sc >= ns);
			default:             bad = (dc >= nd);
		endcase
		// out-of-range channel: no state change, flagged zero result
		if (bad) begin
			r.bad = 1'b1;
			r.chan = (m == cmm_pkg::MODE_FRAME) ? 3'd0 : dc;
			return 1;
		end
		if (m == cmm_pkg::MODE_COEF) begin
			coef_mem[{sc, dc}] = coef;
			return 0;
		end
		if (m == cmm_pkg::MODE_FRAME) begin
			frame_mem[sc] = smp;
			return 0;
		end
		// full precision mac, then gains, round half up and saturate
		acc = 0;
		for (int c = 0; c < ns; c++)
			acc += longint'(frame_mem[c]) * longint'(coef_mem[c*MAX_CH + dc]);
		tot = acc * longint'(cfg_vol_src) + ((longint'(smp) * longint'(cfg_vol_dst)) <<< 12);
		tot += longint'(1) <<< 23;
		val = tot >>> 24;
		if (val > hi) begin
			val = hi;
			r.clip = 1'b1;
		end else if (val < lo) begin
			val = lo;
			r.clip = 1'b1;
		end
		r.mixed = val[15:0];
		r.chan = dc;
		return 1;
	endfunction

	// output beat checker
	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_mix.size() == 0) begin
				$error("unexpected output beat: mixed_sample %0d out_channel %0d",
					mixed_sample, out_channel);
				error_count++;
			end else begin
				want = pending_mix.pop_front();
				if (mixed_sample !== want.mixed) begin
					$error("mixed_sample: expected %0d, got %0d", want.mixed, mixed_sample);
					error_count++;
				end
				if (out_channel !== want.chan) begin
					$error("out_channel: expected %0d, got %0d", want.chan, out_channel);
					error_count++;
				end
				if (clipped !== want.clip) begin
					$error("clipped: expected %0b, got %0b", want.clip, clipped);
					error_count++;
				end
				if (bad_channel !== want.bad) begin
					$error("bad_channel: expected %0b, got %0b", want.bad, bad_channel);
					error_count++;
				end
			end
		end
	end

	// send one input beat, with random sender gaps ahead of it
	task automatic send_beat(input logic [1:0] m, input logic [2:0] sc,
			input logic [2:0] dc, input logic [15:0] smp, input logic [15:0] coef);
		mix_result_t r;
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		src_channel <= sc;
		dst_channel <= dc;
		sample <= smp;
		coefficient <= coef;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		if (mix_predict(m, sc, dc, smp, coef, r))
			pending_mix.push_back(r);
		if (m != cmm_pkg::MODE_NONE)
			beats_sent++;
	endtask

	// stop sending, wait for every expected beat, then let the back end settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write all four registers while idle
	task automatic set_config(input logic [3:0] src_n, input logic [3:0] dst_n,
			input logic [15:0] vd, input logic [15:0] vs);
		logic [15:0] vals [4];
		logic [1:0]  idx [4];
		drain_results();
		// upper bits of the count registers are don't-care
		vals[0] = {12'($urandom_range(0, 4095)), src_n};
		vals[1] = {12'($urandom_range(0, 4095)), dst_n};
		vals[2] = vd;
		vals[3] = vs;
		idx[0] = cmm_pkg::CFG_SRC_CH;
		idx[1] = cmm_pkg::CFG_DST_CH;
		idx[2] = cmm_pkg::CFG_VOL_DST;
		idx[3] = cmm_pkg::CFG_VOL_SRC;
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			forever begin
				@(posedge clk);
				if (cfg_ready)
					break;
			end
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_src_n = src_n;
		cfg_dst_n = dst_n;
		cfg_vol_dst = vd;
		cfg_vol_src = vs;
	endtask

	function automatic logic [2:0] pick_ch(input logic [3:0] n);
		int k;
		k = eff_count(n);
		return (k == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, k - 1));
	endfunction

	// q4.12 value: half full range, half within +-1.0
	function automatic logic [15:0] rand_q412();
		int v;
		if ($urandom_range(0, 1))
			return 16'($urandom);
		v = int'($urandom_range(0, 8192)) - 4096;
		return 16'(v);
	endfunction

	function automatic logic [3:0] rand_count();
		case ($urandom_range(0, 9))
			0: return 4'd1;
			1: return 4'd8;
			2: return 4'($urandom_range(9, 15));
			3: return 4'd0;
			default: return 4'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'd4096;
			4: return 16'($urandom);
			default: return rand_q412();
		endcase
	endfunction

	// reset values: zero matrix, unity gains, two channels each way
	task automatic test_reset_state();
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd0, 16'h7FFF, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd1, 16'h8000, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd2, 16'h1111, 16'h0000);
	endtask

	// out-of-range indexes in every mode, and the unused mode
	task automatic test_bad_channel();
		send_beat(cmm_pkg::MODE_COEF, 3'd2, 3'd0, 16'h0000, 16'h7FFF);
		send_beat(cmm_pkg::MODE_COEF, 3'd0, 3'd7, 16'h0000, 16'h8000);
		send_beat(cmm_pkg::MODE_FRAME, 3'd5, 3'd6, 16'h7FFF, 16'h0000);
		send_beat(cmm_pkg::MODE_NONE, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd3, 16'h4000, 16'h0000);
	endtask

	// full-scale samples, coefficients and gains, with saturation both ways
	task automatic test_extremes();
		set_config(4'd8, 4'd8, 16'h7FFF, 16'h7FFF);
		send_beat(cmm_pkg::MODE_COEF, 3'd7, 3'd7, 16'h0000, 16'h7FFF);
		send_beat(cmm_pkg::MODE_COEF, 3'd0, 3'd7, 16'h0000, 16'h8000);
		send_beat(cmm_pkg::MODE_FRAME, 3'd7, 3'd0, 16'h7FFF, 16'h0000);
		send_beat(cmm_pkg::MODE_FRAME, 3'd0, 3'd0, 16'h8000, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h7FFF, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h8000, 16'h0000);
		set_config(4'd8, 4'd8, 16'h8000, 16'h8000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h8000, 16'h0000);
	endtask

	// unity destination gain with zero source gain, then both gains zero
	task automatic test_zero_gains();
		set_config(4'd8, 4'd8, 16'd4096, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h1234, 16'h0000);
		set_config(4'd8, 4'd8, 16'h0000, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h8000, 16'h0000);
	endtask

	// zero and oversized channel counts, and frame samples kept across a count change
	task automatic test_channel_counts();
		set_config(4'd0, 4'd0, 16'd4096, 16'd4096);
		send_beat(cmm_pkg::MODE_FRAME, 3'd0, 3'd0, 16'h0100, 16'h0000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd0, 16'h0100, 16'h0000);
		send_beat(cmm_pkg::MODE_COEF, 3'd0, 3'd0, 16'h0000, 16'h1000);
		set_config(4'd15, 4'd12, 16'd4096, 16'd2048);
		send_beat(cmm_pkg::MODE_COEF, 3'd7, 3'd7, 16'h0000, 16'h1000);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h0400, 16'h0000);
		set_config(4'd1, 4'd8, 16'd4096, 16'd4096);
		send_beat(cmm_pkg::MODE_MIX, 3'd0, 3'd7, 16'h0000, 16'h0000);
	endtask

	// one random setting: mostly whole frames with random content, some noise
	task automatic run_mix_round(input int n_beats);
		int          start;
		int          ns;
		int          nd;
		int          n_mix;
		logic [1:0]  m;
		set_config(rand_count(), rand_count(), rand_gain(), rand_gain());
		ns = eff_count(cfg_src_n);
		nd = eff_count(cfg_dst_n);
		start = beats_sent;
		while (beats_sent - start < n_beats) begin
			if ($urandom_range(0, 99) < 85) begin
				// coefficient updates, a full source frame, then mixes
				repeat ($urandom_range(0, 4))
					send_beat(cmm_pkg::MODE_COEF, pick_ch(cfg_src_n), pick_ch(cfg_dst_n),
						16'($urandom), rand_q412());
				for (int c = 0; c < ns; c++)
					send_beat(cmm_pkg::MODE_FRAME, 3'(c), 3'($urandom_range(0, 7)),
						16'($urandom), 16'($urandom));
				n_mix = $urandom_range(1, (nd == 0) ? 1 : nd);
				repeat (n_mix)
					send_beat(cmm_pkg::MODE_MIX, 3'($urandom_range(0, 7)),
						pick_ch(cfg_dst_n), 16'($urandom), 16'($urandom));
			end else begin
				m = 2'($urandom_range(0, 3));
				send_beat(m, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					16'($urandom), 16'($urandom));
			end
		end
	endtask

	// random traffic under each idling pattern
	task automatic test_random_traffic();
		int gaps [4];
		int stalls [4];
		gaps[0] = 0;  stalls[0] = 0;
		gaps[1] = 80; stalls[1] = 0;
		gaps[2] = 0;  stalls[2] = 80;
		gaps[3] = 10; stalls[3] = 10;
		for (int p = 0; p < 4; p++) begin
			gap_pct = gaps[p];
			stall_pct = stalls[p];
			repeat (3)
				run_mix_round(128);
		end
		gap_pct = 0;
		stall_pct = 0;
	endtask

	// main sequence
	initial begin
		for (int i = 0; i < MAX_CH*MAX_CH; i++)
			coef_mem[i] = '0;
		for (int i = 0; i < MAX_CH; i++)
			frame_mem[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_bad_channel();
		test_extremes();
		test_zero_gains();
		test_channel_counts();
		test_random_traffic();

		drain_results();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
